// ===== sv/ctt_pkg.sv =====
// Shared types and constants for the code-to-Unicode table block.
// Used by ctt_ctrl and code_to_unicode_table_with_assign_core.
package ctt_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam logic [15:0] UnassignedVal = 16'h25A1;
  localparam logic [15:0] ReservedVal   = 16'h0000;

  typedef enum logic [1:0] {
    CmdWrite  = 2'd0,
    CmdLookup = 2'd1,
    CmdFind   = 2'd2,
    CmdAdd    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatDone     = 2'd0,
    StatNotFound = 2'd1,
    StatFull     = 2'd2,
    StatPresent  = 2'd3
  } status_e;

  // Control from the sequencer to the tail of the ring.
  typedef struct packed {
    logic        wr_en;
    logic [15:0] wdata;
  } ring_ctrl_t;

endpackage

// ===== sv/code_to_unicode_table_with_assign_core.sv =====
// Write and lookup wait for the target entry to reach the head; find scans the ring once;
// add scans once and, when it assigns a new code, then waits for that entry to reach the head.
// Throughput: one transaction at a time; the table ring rotates one entry per
// cycle past a single head compare.
// Reset: asynchronous, active low; code 0 holds 0x0000, all other codes 0x25A1,
// and the next free code is 1. No clearing pass is needed.
module code_to_unicode_table_with_assign_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [9:2] code, [25:10] unicode, [31:26] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] result_code, [23:8] result_unicode, [25:24] status, [31:26] zero
  output logic [31:0] m_axis_tdata
);

  // Cell 0 is the head of the ring and always holds the entry whose code
  // equals the sequencer's pointer. Every cycle each cell takes its upper
  // neighbor's entry, and the last cell takes the head entry back (or the
  // new value on a write), so each entry passes the head in turn.
  logic [15:0]         cell_q [ctt_pkg::TableDepth];
  ctt_pkg::ring_ctrl_t ring;

  logic [7:0]  res_code;
  logic [15:0] res_unicode;
  logic [1:0]  res_status;

  for (genvar i = 0; i < ctt_pkg::TableDepth; i++) begin : g_cell
    logic [15:0] init;
    logic [15:0] nbr;
    logic        load;

    // Hold the reserved value in code 0 after reset.
    assign init = (i == 0) ? ctt_pkg::ReservedVal : ctt_pkg::UnassignedVal;

    if (i == ctt_pkg::TableDepth - 1) begin : g_tail
      // Close the ring: the head entry returns, replaced on a write.
      assign nbr  = cell_q[0];
      assign load = ring.wr_en;
    end else begin : g_body
      assign nbr  = cell_q[i+1];
      assign load = 1'b0;
    end

    ctt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .init_i  (init),
      .d_i     (nbr),
      .load_i  (load),
      .wdata_i (ring.wdata),
      .q_o     (cell_q[i])
    );
  end

  // Sequence commands, track the free code and register the result.
  ctt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tdata[1:0]),
    .in_code_i     (s_axis_tdata[9:2]),
    .in_unicode_i  (s_axis_tdata[25:10]),
    .head_i        (cell_q[0]),
    .ring_o        (ring),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_code_o    (res_code),
    .out_unicode_o (res_unicode),
    .out_status_o  (res_status)
  );

  // Pack the result fields, lowest field first, zero-filled to 32 bits.
  assign m_axis_tdata = {6'b0, res_status, res_unicode, res_code};

endmodule

// ===== sv/ctt_cell.sv =====
// One cell of the rotating table ring: holds one 16-bit entry.
// Depends on nothing; instantiated by the top level.
module ctt_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] init_i,
  input  logic [15:0] d_i,
  input  logic        load_i,
  input  logic [15:0] wdata_i,
  output logic [15:0] q_o
);

  logic [15:0] entry_q;
  logic [15:0] entry_d;

  // Take the neighbor's entry, or a new value when loading.
  assign entry_d = load_i ? wdata_i : d_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= init_i;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign q_o = entry_q;

endmodule

// ===== sv/ctt_ctrl.sv =====
// Command sequencer: tracks the ring position, scans, seeks, writes and
// registers the result. Depends on ctt_pkg.
module ctt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_cmd_i,
  input  logic [7:0]            in_code_i,
  input  logic [15:0]           in_unicode_i,
  input  logic [15:0]           head_i,
  output ctt_pkg::ring_ctrl_t   ring_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_code_o,
  output logic [15:0]           out_unicode_o,
  output logic [1:0]            out_status_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StSeek = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  ctt_pkg::cmd_e               cmd_q, cmd_d;
  logic [15:0]                 key_q, key_d;
  logic [ctt_pkg::IdxW-1:0]    ptr_q, ptr_d;
  logic [ctt_pkg::IdxW-1:0]    target_q, target_d;
  logic [ctt_pkg::IdxW-1:0]    cnt_q, cnt_d;
  logic                        found_q, found_d;
  logic [ctt_pkg::IdxW-1:0]    best_q, best_d;
  logic [ctt_pkg::CntW-1:0]    nfc_q, nfc_d;
  logic [7:0]                  res_code_q, res_code_d;
  logic [15:0]                 res_uni_q, res_uni_d;
  ctt_pkg::status_e            res_st_q, res_st_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_code_q, out_code_d;
  logic [15:0]                 out_uni_q, out_uni_d;
  ctt_pkg::status_e            out_st_q, out_st_d;

  logic                        in_fire;
  logic                        out_free;
  logic                        hit_now;
  logic                        scan_found;
  logic [ctt_pkg::IdxW-1:0]    scan_best;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Lowest matching code over one revolution, folding in the head now.
  assign hit_now    = (head_i == key_q) && (!found_q || (ptr_q < best_q));
  assign scan_found = found_q || hit_now;
  assign scan_best  = hit_now ? ptr_q : best_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    target_d    = target_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    best_d      = best_q;
    nfc_d       = nfc_q;
    res_code_d  = res_code_q;
    res_uni_d   = res_uni_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_uni_d   = out_uni_q;
    out_st_d    = out_st_q;
    ring_o      = '0;

    // The ring rotates every cycle; the head holds entry ptr_q.
    if (ptr_q == ctt_pkg::IdxW'(ctt_pkg::TableDepth - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + 1'b1;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          cmd_d   = ctt_pkg::cmd_e'(in_cmd_i);
          key_d   = in_unicode_i;
          cnt_d   = '0;
          found_d = 1'b0;
          best_d  = '0;
          if (in_cmd_i == ctt_pkg::CmdWrite || in_cmd_i == ctt_pkg::CmdLookup) begin
            if ({1'b0, in_code_i} >= 9'(ctt_pkg::TableDepth)) begin
              res_code_d = in_code_i;
              res_uni_d  = ctt_pkg::UnassignedVal;
              res_st_d   = ctt_pkg::StatNotFound;
              state_d    = StDone;
            end else begin
              target_d = in_code_i[ctt_pkg::IdxW-1:0];
              state_d  = StSeek;
            end
          end else begin
            state_d = StScan;
          end
        end
      end

      StScan: begin
        found_d = scan_found;
        best_d  = scan_best;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == ctt_pkg::IdxW'(ctt_pkg::TableDepth - 1)) begin
          if (scan_found) begin
            res_code_d = 8'(scan_best);
            res_uni_d  = key_q;
            res_st_d   = (cmd_q == ctt_pkg::CmdFind) ? ctt_pkg::StatDone
                                                     : ctt_pkg::StatPresent;
            state_d    = StDone;
          end else if (cmd_q == ctt_pkg::CmdFind) begin
            res_code_d = '0;
            res_uni_d  = '0;
            res_st_d   = ctt_pkg::StatNotFound;
            state_d    = StDone;
          end else if (nfc_q >= ctt_pkg::CntW'(ctt_pkg::TableDepth - 1)) begin
            res_code_d = '0;
            res_uni_d  = '0;
            res_st_d   = ctt_pkg::StatFull;
            state_d    = StDone;
          end else begin
            target_d = nfc_q[ctt_pkg::IdxW-1:0];
            state_d  = StSeek;
          end
        end
      end

      StSeek: begin
        // Wait for the target entry to reach the head, then act on it.
        if (ptr_q == target_q) begin
          res_code_d = 8'(target_q);
          res_st_d   = ctt_pkg::StatDone;
          if (cmd_q == ctt_pkg::CmdLookup) begin
            res_uni_d = head_i;
          end else begin
            ring_o.wr_en = 1'b1;
            ring_o.wdata = key_q;
            res_uni_d    = key_q;
          end
          if (cmd_q == ctt_pkg::CmdAdd) begin
            nfc_d = nfc_q + 1'b1;
          end
          state_d = StDone;
        end
      end

      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_code_d  = res_code_q;
          out_uni_d   = res_uni_q;
          out_st_d    = res_st_q;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      nfc_q       <= ctt_pkg::CntW'(1);
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      nfc_q       <= nfc_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    target_q   <= target_d;
    best_q     <= best_d;
    res_code_q <= res_code_d;
    res_uni_q  <= res_uni_d;
    res_st_q   <= res_st_d;
    out_code_q <= out_code_d;
    out_uni_q  <= out_uni_d;
    out_st_q   <= out_st_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_code_o    = out_code_q;
  assign out_unicode_o = out_uni_q;
  assign out_status_o  = out_st_q;

endmodule
